>>> hdl/charlieplexed_seven_segment_scanner_defines.svh
// ---------------------------------------------------------------------------
// Seven-segment scanner assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef CHARLIEPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH
`define CHARLIEPLEXED_SEVEN_SEGMENT_SCANNER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CS7S_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication
`define CS7S_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`else

`define CS7S_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CS7S_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/cs7s_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment scanner package
// Shared types, codes, glyph and charlieplex tables.
// ---------------------------------------------------------------------------
package cs7s_pkg;

    localparam int NUM_SEGMENTS_DEF = 23;
    localparam int NUM_PINS_DEF     = 6;

    localparam int SEG_W   = 5;
    localparam int PIN_W   = 3;
    localparam int VAL_W   = 16;
    localparam int MOD_W   = 10;
    localparam int DIGIT_W = 4;
    localparam int GLYPH_W = 7;
    localparam int PAT_W   = 23;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // command codes
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT = 1'd1;

    // blanking codes
    localparam logic [1:0] BLANK_NONE    = 2'd0;
    localparam logic [1:0] BLANK_HUND    = 2'd1;
    localparam logic [1:0] BLANK_HT      = 2'd2;
    localparam logic [1:0] BLANK_HT_ALT  = 2'd3;

    // dot code bits
    localparam int DOT_RIGHT_BIT = 0;
    localparam int DOT_LEFT_BIT  = 1;

    typedef logic [SEG_W-1:0]   t_seg;
    typedef logic [PIN_W-1:0]   t_pin;
    typedef logic [VAL_W-1:0]   t_value;
    typedef logic [MOD_W-1:0]   t_mod;
    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [GLYPH_W-1:0] t_glyph;
    typedef logic [PAT_W-1:0]   t_pattern;

    typedef struct packed {
        logic [1:0] blank;
        logic [1:0] dots;
    } t_fmt;

    typedef struct packed {
        t_pin hi;
        t_pin lo;
    } t_pin_pair;

    function automatic t_glyph glyph_of(input t_digit d);
        t_glyph g;
        case (d)
            4'd0:    g = 7'b0111111;
            4'd1:    g = 7'b0000110;
            4'd2:    g = 7'b1011011;
            4'd3:    g = 7'b1001111;
            4'd4:    g = 7'b1100110;
            4'd5:    g = 7'b1101101;
            4'd6:    g = 7'b1111101;
            4'd7:    g = 7'b0100111;
            4'd8:    g = 7'b1111111;
            4'd9:    g = 7'b1101111;
            default: g = '0;
        endcase
        return g;
    endfunction

    // drive/sink pin of each segment: digits a..g, then left and right dot
    function automatic t_pin_pair seg_pins(input t_seg s);
        t_pin_pair p;
        case (s)
            5'd0:    p = '{hi: 3'd0, lo: 3'd1};
            5'd1:    p = '{hi: 3'd0, lo: 3'd2};
            5'd2:    p = '{hi: 3'd0, lo: 3'd3};
            5'd3:    p = '{hi: 3'd0, lo: 3'd4};
            5'd4:    p = '{hi: 3'd0, lo: 3'd5};
            5'd5:    p = '{hi: 3'd1, lo: 3'd2};
            5'd6:    p = '{hi: 3'd1, lo: 3'd3};
            5'd7:    p = '{hi: 3'd1, lo: 3'd0};
            5'd8:    p = '{hi: 3'd2, lo: 3'd0};
            5'd9:    p = '{hi: 3'd3, lo: 3'd0};
            5'd10:   p = '{hi: 3'd4, lo: 3'd0};
            5'd11:   p = '{hi: 3'd5, lo: 3'd0};
            5'd12:   p = '{hi: 3'd1, lo: 3'd4};
            5'd13:   p = '{hi: 3'd1, lo: 3'd5};
            5'd14:   p = '{hi: 3'd2, lo: 3'd1};
            5'd15:   p = '{hi: 3'd3, lo: 3'd1};
            5'd16:   p = '{hi: 3'd4, lo: 3'd1};
            5'd17:   p = '{hi: 3'd5, lo: 3'd1};
            5'd18:   p = '{hi: 3'd3, lo: 3'd2};
            5'd19:   p = '{hi: 3'd4, lo: 3'd2};
            5'd20:   p = '{hi: 3'd5, lo: 3'd2};
            5'd21:   p = '{hi: 3'd2, lo: 3'd3};
            5'd22:   p = '{hi: 3'd2, lo: 3'd4};
            default: p = '{hi: 3'd0, lo: 3'd0};
        endcase
        return p;
    endfunction

    // (top nibble * 4096) mod 1000
    function automatic t_mod nibble_mod(input logic [3:0] n);
        t_mod m;
        case (n)
            4'd0:    m = 10'd0;
            4'd1:    m = 10'd96;
            4'd2:    m = 10'd192;
            4'd3:    m = 10'd288;
            4'd4:    m = 10'd384;
            4'd5:    m = 10'd480;
            4'd6:    m = 10'd576;
            4'd7:    m = 10'd672;
            4'd8:    m = 10'd768;
            4'd9:    m = 10'd864;
            4'd10:   m = 10'd960;
            4'd11:   m = 10'd56;
            4'd12:   m = 10'd152;
            4'd13:   m = 10'd248;
            4'd14:   m = 10'd344;
            4'd15:   m = 10'd440;
            default: m = 10'd0;
        endcase
        return m;
    endfunction

    // value mod 1000: split at bit 12, reduce each part, one final correction
    function automatic t_mod value_mod1000(input t_value v);
        logic [11:0] lo;
        t_mod        lo_mod;
        logic [10:0] sum;
        lo = v[11:0];
        if (lo >= 12'd4000) begin
            lo_mod = 10'(lo - 12'd4000);
        end else if (lo >= 12'd3000) begin
            lo_mod = 10'(lo - 12'd3000);
        end else if (lo >= 12'd2000) begin
            lo_mod = 10'(lo - 12'd2000);
        end else if (lo >= 12'd1000) begin
            lo_mod = 10'(lo - 12'd1000);
        end else begin
            lo_mod = lo[9:0];
        end
        sum = {1'b0, lo_mod} + {1'b0, nibble_mod(v[15:12])};
        if (sum >= 11'd1000) begin
            return 10'(sum - 11'd1000);
        end
        return sum[9:0];
    endfunction

endpackage

>>> hdl/cs7s_if.sv
// ---------------------------------------------------------------------------
// Seven-segment scanner channels
// Valid/ready interfaces for the command, result and register channels.
// ---------------------------------------------------------------------------
interface cs7s_in_if;
    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [15:0]            new_value;

    modport source (output valid, output cmd, output new_value, input ready);
    modport sink   (input valid, input cmd, input new_value, output ready);
endinterface

interface cs7s_out_if;
    logic                   valid;
    logic                   ready;
    logic [4:0]             scan_segment;
    logic                   drive_on;
    logic [2:0]             pin_high;
    logic [2:0]             pin_low;

    modport source (output valid, output scan_segment, output drive_on,
                    output pin_high, output pin_low, input ready);
    modport sink   (input valid, input scan_segment, input drive_on,
                    input pin_high, input pin_low, output ready);
endinterface

interface cs7s_cfg_if;
    logic                   valid;
    logic                   ready;
    logic [0:0]             index;
    logic [3:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/cs7s_pattern.sv
// ---------------------------------------------------------------------------
// Seven-segment scanner pattern builder
// Splits the stored value into digits and forms the 23-bit segment pattern.
// ---------------------------------------------------------------------------
module cs7s_pattern (
    input  cs7s_pkg::t_mod     i_value,
    input  cs7s_pkg::t_fmt     i_fmt,
    output cs7s_pkg::t_pattern o_pattern
);
    import cs7s_pkg::*;

    t_digit     hund;
    t_digit     tens;
    t_digit     units;
    t_mod       hund_base;
    logic [6:0] rem;
    logic [6:0] tens_base;
    t_glyph     g_hund;
    t_glyph     g_tens;
    t_glyph     g_units;

    // digit extraction by parallel threshold compares
    always_comb begin
        hund      = '0;
        hund_base = '0;
        for (int k = 1; k < 10; k++) begin
            if (i_value >= MOD_W'(k * 100)) begin
                hund      = DIGIT_W'(k);
                hund_base = MOD_W'(k * 100);
            end
        end
        rem = 7'(i_value - hund_base);

        tens      = '0;
        tens_base = '0;
        for (int k = 1; k < 10; k++) begin
            if (rem >= 7'(k * 10)) begin
                tens      = DIGIT_W'(k);
                tens_base = 7'(k * 10);
            end
        end
        units = DIGIT_W'(rem - tens_base);
    end

    always_comb begin
        g_hund  = glyph_of(hund);
        g_tens  = glyph_of(tens);
        g_units = glyph_of(units);
        case (i_fmt.blank) inside
            BLANK_HUND: begin
                if (hund == '0) g_hund = '0;
            end
            BLANK_HT, BLANK_HT_ALT: begin
                if (hund == '0) g_hund = '0;
                if (hund == '0 && tens == '0) g_tens = '0;
            end
            default: ;
        endcase
        o_pattern = {i_fmt.dots[DOT_RIGHT_BIT], i_fmt.dots[DOT_LEFT_BIT],
                     g_units, g_tens, g_hund};
    end

endmodule

>>> hdl/charlieplexed_seven_segment_scanner.sv
// ---------------------------------------------------------------------------
// Charlieplexed seven-segment scanner
// Three digits and two dots on a six-pin charlieplexed display.
// ---------------------------------------------------------------------------
// A load transaction (cmd 1) stores new_value mod 1000 and produces no result;
// a tick transaction (cmd 0) produces one result naming the segment scanned
// and, if that segment is lit, the pin to drive high and the pin to sink.
// Each transaction passes through the input register, and a tick then through
// the result register; one transaction is taken per clock unless a held result
// stalls it. The result register frees as soon as its transaction is taken, so
// a held result stalls input only for ticks. Registers (enable, format) are set
// over the always-ready register channel; the user must write them only while
// no transaction is in flight, as the block does not enforce it. With enable
// low a tick reports segment 0 with all pins released and restarts the scan.
`include "charlieplexed_seven_segment_scanner_defines.svh"

module charlieplexed_seven_segment_scanner #(
    parameter int NUM_SEGMENTS = cs7s_pkg::NUM_SEGMENTS_DEF,
    parameter int NUM_PINS     = cs7s_pkg::NUM_PINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cs7s_cfg_if.sink    i_cfg,
    cs7s_in_if.sink     i_in,
    cs7s_out_if.source  o_out
);
    import cs7s_pkg::*;

    localparam int                SL_W      = SEG_W + 1;
    localparam logic [SL_W-1:0]   SEG_LIMIT = SL_W'(NUM_SEGMENTS);
    localparam logic [PIN_W:0]    PIN_LIMIT = (PIN_W + 1)'(NUM_PINS);
    localparam int                PAT_EXT_W = 2 ** SEG_W;

    // configuration and state
    logic       r_enable;
    t_fmt       r_fmt;
    t_mod       r_mod;
    t_seg       r_scan;

    // input register
    logic       r_in_valid;
    logic       r_in_cmd;
    t_value     r_in_value;

    // result register
    logic       r_out_valid;
    t_seg       r_out_seg;
    logic       r_out_on;
    t_pin       r_out_hi;
    t_pin       r_out_lo;

    logic                 out_free;
    logic                 stage_go;
    logic                 in_ready;
    logic                 tick_go;
    t_pattern             pattern;
    logic [PAT_EXT_W-1:0] pat_ext;
    t_seg                 seg;
    logic [SL_W-1:0]      seg_inc;
    t_pin_pair            pins;
    logic                 pins_ok;
    logic                 lit;
    t_seg                 n_scan;
    t_seg                 n_out_seg;
    logic                 n_out_on;
    t_pin                 n_out_hi;
    t_pin                 n_out_lo;

    cs7s_pattern u_pattern (
        .i_value   (r_mod),
        .i_fmt     (r_fmt),
        .o_pattern (pattern)
    );

    // handshake: a load never needs the result register
    assign out_free = !r_out_valid || o_out.ready;
    assign stage_go = r_in_valid && (r_in_cmd == CMD_LOAD || out_free);
    assign tick_go  = stage_go && r_in_cmd == CMD_TICK;
    assign in_ready = !r_in_valid || stage_go;

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        seg     = ({1'b0, r_scan} >= SEG_LIMIT) ? '0 : r_scan;
        seg_inc = {1'b0, seg} + SL_W'(1);
        pat_ext = PAT_EXT_W'(pattern);
        pins    = seg_pins(seg);
        pins_ok = ({1'b0, pins.hi} < PIN_LIMIT) && ({1'b0, pins.lo} < PIN_LIMIT);
        lit     = r_enable && pat_ext[seg] && pins_ok;

        n_out_seg = r_enable ? seg : '0;
        n_out_on  = lit;
        n_out_hi  = lit ? pins.hi : '0;
        n_out_lo  = lit ? pins.lo : '0;

        if (!r_enable || seg_inc >= SEG_LIMIT) begin
            n_scan = '0;
        end else begin
            n_scan = seg_inc[SEG_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'b0;
            r_fmt       <= '0;
            r_mod       <= '0;
            r_scan      <= '0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_ENABLE: r_enable <= i_cfg.data[0];
                    CFG_FORMAT: r_fmt    <= t_fmt'(i_cfg.data);
                    default: ;
                endcase
            end
            if (in_ready) begin
                r_in_valid <= i_in.valid;
            end
            if (stage_go) begin
                if (r_in_cmd == CMD_LOAD) begin
                    r_mod <= value_mod1000(r_in_value);
                end else begin
                    r_scan <= n_scan;
                end
            end
            if (out_free) begin
                r_out_valid <= tick_go;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_in_cmd   <= i_in.cmd;
            r_in_value <= i_in.new_value;
        end
        if (tick_go) begin
            r_out_seg <= n_out_seg;
            r_out_on  <= n_out_on;
            r_out_hi  <= n_out_hi;
            r_out_lo  <= n_out_lo;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.scan_segment = r_out_seg;
    assign o_out.drive_on     = r_out_on;
    assign o_out.pin_high     = r_out_hi;
    assign o_out.pin_low      = r_out_lo;

    `CS7S_ASSERT_IMP(a_scan_bound, i_clk, i_rst_n, 1'b1, {1'b0, r_scan} < SEG_LIMIT)
    `CS7S_ASSERT_IMP(a_pins_distinct, i_clk, i_rst_n, r_out_valid && r_out_on, r_out_hi != r_out_lo)
    `CS7S_ASSERT_IMP(a_dark_released, i_clk, i_rst_n, r_out_valid && !r_out_on, r_out_hi == '0 && r_out_lo == '0)
    `CS7S_ASSERT_IMP(a_seg_bound, i_clk, i_rst_n, r_out_valid, {1'b0, r_out_seg} < SEG_LIMIT)
    `CS7S_ASSERT_NXT(a_load_silent, i_clk, i_rst_n, r_in_valid && r_in_cmd == CMD_LOAD && out_free, !r_out_valid)

endmodule

>>> test/charlieplexed_seven_segment_scanner_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Charlieplexed seven-segment scanner testbench
// Sends load and scan-tick transactions and writes the enable and format
// registers between phases. Scan results are checked against a local model of
// the digit split, blanking, dots and pin map, or a typed row's want. A short
// directed table comes first, then random phases with stalls on both channels.
// ---------------------------------------------------------------------------
module charlieplexed_seven_segment_scanner_test;
    import cs7s_pkg::*;

    localparam int SEG_COUNT    = NUM_SEGMENTS_DEF;
    localparam int PIN_COUNT    = NUM_PINS_DEF;
    localparam int MAPPED_SEGS  = 23;
    localparam int DRAIN_CYCLES = 6;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 75;
    localparam int MAX_PRINTED  = 40;
    localparam int LIMIT_NS     = 2_000_000;

    localparam logic [1:0] DOTS_NONE  = 2'd0;
    localparam logic [1:0] DOTS_RIGHT = 2'd1;
    localparam logic [1:0] DOTS_LEFT  = 2'd2;
    localparam logic [1:0] DOTS_BOTH  = 2'd3;

    localparam t_glyph DIGIT_GLYPH [10] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F
    };
    localparam t_pin DRIVE_PIN [MAPPED_SEGS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1,
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd1, 3'd1,
        3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5,
        3'd2, 3'd2
    };
    localparam t_pin SINK_PIN [MAPPED_SEGS] = '{
        3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd2, 3'd3,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd4, 3'd5,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd4
    };

    typedef struct packed {
        t_seg seg;
        logic on;
        t_pin hi;
        t_pin lo;
    } t_seg_drive;

    typedef enum logic {ROW_CFG, ROW_XFER} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic                   cmd;
        t_value                 value;
        logic                   typed;
        t_seg_drive             want;
    } t_row;

    localparam int NUM_ROWS = 28;
    // cfg rows carry the register data in value
    localparam t_row DIRECTED [NUM_ROWS] = '{
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b1, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'hFFFF,  1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'hFFFF,  1'b1, '0},
        '{ROW_CFG,  CFG_ENABLE, CMD_TICK, 16'd1,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_CFG,  CFG_FORMAT, CMD_TICK, {12'd0, BLANK_HT, DOTS_LEFT}, 1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'd1000,  1'b0, '0},
        '{ROW_CFG,  CFG_FORMAT, CMD_TICK, {12'd0, BLANK_HT_ALT, DOTS_BOTH}, 1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'd7,     1'b0, '0},
        '{ROW_CFG,  CFG_FORMAT, CMD_TICK, {12'd0, BLANK_HUND, DOTS_RIGHT}, 1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'd59,    1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_CFG,  CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b1, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_LOAD, 16'd808,   1'b0, '0},
        '{ROW_CFG,  CFG_FORMAT, CMD_TICK, {12'd0, BLANK_NONE, DOTS_NONE}, 1'b0, '0},
        '{ROW_CFG,  CFG_ENABLE, CMD_TICK, 16'hF,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0},
        '{ROW_XFER, CFG_ENABLE, CMD_TICK, 16'd0,     1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    cs7s_cfg_if cfg_ch ();
    cs7s_in_if  in_ch ();
    cs7s_out_if out_ch ();

    charlieplexed_seven_segment_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // model state
    logic       display_on;
    t_fmt       display_fmt;
    t_value     held_value;
    int         scan_pos;

    t_seg_drive expected_scans [$];
    int         idle_pct;
    int         error_count;
    int         tick_count;
    int         load_count;
    int         lit_count;
    int         reg_writes;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_NS);
        $display("timeout with %0d scan results outstanding", expected_scans.size());
        $display("charlieplexed_seven_segment_scanner test failed");
        $finish;
    end

    task automatic flag_error(input string msg);
        if (error_count < MAX_PRINTED) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic t_pattern lit_pattern(input t_value value, input t_fmt fmt);
        int     v;
        int     hund;
        int     tens;
        int     units;
        t_glyph gh;
        t_glyph gt;
        t_glyph gu;
        v     = int'(value) % 1000;
        units = v % 10;
        tens  = (v / 10) % 10;
        hund  = v / 100;
        gh    = DIGIT_GLYPH[hund];
        gt    = DIGIT_GLYPH[tens];
        gu    = DIGIT_GLYPH[units];
        // blanking code three behaves as hundreds+tens
        if (fmt.blank[1]) begin
            if (hund == 0 && tens == 0) gt = '0;
            if (hund == 0) gh = '0;
        end else if (fmt.blank[0]) begin
            if (hund == 0) gh = '0;
        end
        return {fmt.dots[DOT_RIGHT_BIT], fmt.dots[DOT_LEFT_BIT], gu, gt, gh};
    endfunction

    // works out the result of one tick and advances the scan
    function automatic t_seg_drive next_scan();
        t_seg_drive r;
        t_pattern   pat;
        r = '0;
        if (!display_on) begin
            scan_pos = 0;
            return r;
        end
        if (scan_pos >= SEG_COUNT) scan_pos = 0;
        r.seg = t_seg'(scan_pos);
        pat = lit_pattern(held_value, display_fmt);
        if (scan_pos < MAPPED_SEGS && pat[scan_pos]) begin
            if (DRIVE_PIN[scan_pos] < PIN_COUNT && SINK_PIN[scan_pos] < PIN_COUNT) begin
                r.on = 1'b1;
                r.hi = DRIVE_PIN[scan_pos];
                r.lo = SINK_PIN[scan_pos];
            end
        end
        scan_pos = (scan_pos + 1 >= SEG_COUNT) ? 0 : scan_pos + 1;
        return r;
    endfunction

    function automatic t_value pick_value();
        case ($urandom_range(5))
            0:       return t_value'($urandom);
            1:       return t_value'($urandom_range(9));
            2:       return t_value'($urandom_range(99));
            3:       return t_value'(1000 * $urandom_range(65) + $urandom_range(99));
            4:       return t_value'(100 * $urandom_range(655));
            default: return t_value'(16'hFFFF - $urandom_range(63));
        endcase
    endfunction

    task automatic send_item(input logic cmd, input t_value value, input logic typed,
                             input t_seg_drive want);
        t_seg_drive pred;
        while ($urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.new_value <= value;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_LOAD) begin
            held_value = value;
            load_count++;
        end else begin
            pred = next_scan();
            expected_scans.push_back(typed ? want : pred);
            tick_count++;
        end
    endtask

    // hold the sender off until every scan result is back and the pipe is empty
    task automatic settle();
        in_ch.valid <= 1'b0;
        while (expected_scans.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        if (idx == CFG_ENABLE) begin
            display_on = value[0];
        end else begin
            display_fmt = t_fmt'(value);
        end
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_scan();
        t_seg_drive want;
        if (expected_scans.size() == 0) begin
            flag_error($sformatf("unexpected scan result, segment %0d", out_ch.scan_segment));
            return;
        end
        want = expected_scans.pop_front();
        if (out_ch.scan_segment !== want.seg || out_ch.drive_on !== want.on ||
            out_ch.pin_high !== want.hi || out_ch.pin_low !== want.lo) begin
            flag_error($sformatf("seg %0d on %0b hi %0d lo %0d, want seg %0d on %0b hi %0d lo %0d",
                out_ch.scan_segment, out_ch.drive_on, out_ch.pin_high, out_ch.pin_low,
                want.seg, want.on, want.hi, want.lo));
        end
        if (out_ch.drive_on === 1'b1) lit_count++;
    endtask

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
        if (i_rst_n && out_ch.valid && out_ch.ready) check_scan();
    end

    initial begin
        logic                  en;
        logic [CFG_DATA_W-1:0] fmt;
        logic                  cmd;
        idle_pct    = 34;
        error_count = 0;
        tick_count  = 0;
        load_count  = 0;
        lit_count   = 0;
        reg_writes  = 0;
        display_on  = 1'b0;
        display_fmt = '0;
        held_value  = '0;
        scan_pos    = 0;

        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.cmd       <= CMD_TICK;
        in_ch.new_value <= '0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_ENABLE;
        cfg_ch.data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[r]) begin
            if (DIRECTED[r].kind == ROW_CFG) begin
                settle();
                write_reg(DIRECTED[r].idx, DIRECTED[r].value[CFG_DATA_W-1:0]);
            end else begin
                send_item(DIRECTED[r].cmd, DIRECTED[r].value, DIRECTED[r].typed,
                          DIRECTED[r].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            // phase 5 runs disabled, phases 0 and 1 take the format extremes
            en  = (p != 5);
            fmt = (p == 0) ? 4'h0 : (p == 1) ? 4'hF : 4'($urandom_range(15));
            write_reg(CFG_ENABLE, {3'($urandom_range(7)), en});
            write_reg(CFG_FORMAT, fmt);
            idle_pct = (p == 3) ? 0 : 34;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (p == 6 && i == PHASE_ITEMS / 2) settle();
                cmd = ($urandom_range(99) < 12) ? CMD_LOAD : CMD_TICK;
                send_item(cmd, pick_value(), 1'b0, '0);
            end
        end

        idle_pct = 34;
        settle();
        $display("ran %0d ticks (%0d lit) and %0d loads over %0d register writes",
                 tick_count, lit_count, load_count, reg_writes);
        if (error_count == 0) begin
            $display("charlieplexed_seven_segment_scanner test passed");
        end else begin
            $display("%0d mismatches", error_count);
            $display("charlieplexed_seven_segment_scanner test failed");
        end
        $finish;
    end

endmodule
